// File: design/ssmd_pkg.sv
// Shared types and constants for the signed add/sub/mul/div unit.
package ssmd_pkg;

    localparam int WORD_W   = 32;
    localparam int SIGN_BIT = WORD_W - 1;
    localparam int CNT_W    = $clog2(WORD_W);
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                     divide_by_zero;
    } rsp_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]        kind;
        logic              fast;       // result already known, no iteration
        logic              dz;
        logic              neg;
        logic [WORD_W-1:0] fast_value;
        logic [WORD_W-1:0] mag_a;
        logic [WORD_W-1:0] mag_b;
    } cmd_t;

endpackage

// File: design/ssmd_front.sv
// Front end: classifies a request, resolves add/sub and divide by zero, forms magnitudes.
module ssmd_front (
    input  ssmd_pkg::req_t req,
    output ssmd_pkg::cmd_t cmd
);
    import ssmd_pkg::*;

    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;

    assign a = WORD_W'(req.operand_a);
    assign b = WORD_W'(req.operand_b);

    always_comb
    begin
        cmd.kind       = req.kind;
        cmd.neg        = a[SIGN_BIT] ^ b[SIGN_BIT];
        cmd.mag_a      = a[SIGN_BIT] ? (WORD_W'(0) - a) : a;
        cmd.mag_b      = b[SIGN_BIT] ? (WORD_W'(0) - b) : b;
        cmd.fast       = 1'b0;
        cmd.dz         = 1'b0;
        cmd.fast_value = '0;
        unique case (req.kind)
            KIND_ADD:
            begin
                cmd.fast       = 1'b1;
                cmd.fast_value = a + b;
            end
            KIND_SUB:
            begin
                cmd.fast       = 1'b1;
                cmd.fast_value = a - b;
            end
            KIND_MUL:
            begin
                cmd.fast = 1'b0;
            end
            KIND_DIV:
            begin
                if (b == '0)
                begin
                    cmd.fast = 1'b1;
                    cmd.dz   = 1'b1;
                end
            end
            default:
            begin
                cmd.fast = 1'b0;
            end
        endcase
    end

endmodule

// File: design/ssmd_cmd_queue.sv
// Short command queue between the front end and the back end.
module ssmd_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  ssmd_pkg::cmd_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output ssmd_pkg::cmd_t rd_data,
    output logic           q_empty
);
    import ssmd_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]    wptr_reg;
    logic [Q_AW-1:0]    wptr_next;
    logic [Q_AW-1:0]    rptr_reg;
    logic [Q_AW-1:0]    rptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/ssmd_back.sv
// Back end: iterative shift-add multiply, restoring divide, sign fix-up and result register.
module ssmd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ssmd_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    output ssmd_pkg::rsp_t rsp,
    output logic           empty,
    input  logic           pop
);
    import ssmd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIX  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] x_next;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] y_next;
    logic              neg_reg;
    logic              neg_next;
    logic              is_mul_reg;
    logic              is_mul_next;
    logic [WORD_W-1:0] res_reg;
    logic [WORD_W-1:0] res_next;
    logic              dz_reg;
    logic              dz_next;
    rsp_t              out_reg;
    rsp_t              out_next;

    logic [WORD_W-1:0] mul_sum;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_diff;
    logic              fits;
    logic [WORD_W-1:0] fix_src;
    logic              out_load;
    logic              out_take;

    assign mul_sum   = acc_reg + (y_reg[0] ? x_reg : '0);
    assign rem_shift = {acc_reg, x_reg[SIGN_BIT]};
    assign rem_diff  = rem_shift - {1'b0, y_reg};
    assign fits      = !rem_diff[WORD_W];
    assign fix_src   = is_mul_reg ? acc_reg : x_reg;

    assign out_take  = pop && out_valid_reg;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_take);
    assign cmd_pop   = (state_reg == S_IDLE) && !cmd_empty;
    assign empty     = !out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        neg_next       = neg_reg;
        is_mul_next    = is_mul_reg;
        res_next       = res_reg;
        dz_next        = dz_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    neg_next    = cmd.neg;
                    is_mul_next = (cmd.kind == KIND_MUL);
                    dz_next     = cmd.dz;
                    res_next    = cmd.fast_value;
                    acc_next    = '0;
                    x_next      = cmd.mag_a;
                    y_next      = cmd.mag_b;
                    cnt_next    = '0;
                    if (cmd.fast)
                    begin
                        state_next = S_OUT;
                    end
                    else if (cmd.kind == KIND_MUL)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_MUL:
            begin
                acc_next = mul_sum;
                x_next   = {x_reg[WORD_W-2:0], 1'b0};
                y_next   = {1'b0, y_reg[WORD_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_DIV:
            begin
                // acc holds the partial remainder, x shifts dividend bits out and quotient bits in
                acc_next = fits ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
                x_next   = {x_reg[WORD_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                res_next   = neg_reg ? (WORD_W'(0) - fix_src) : fix_src;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_next.result         = res_reg;
                    out_next.divide_by_zero = dz_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        neg_reg    <= neg_next;
        is_mul_reg <= is_mul_next;
        res_reg    <= res_next;
        dz_reg     <= dz_next;
        out_reg    <= out_next;
    end

endmodule

// File: design/signed_add_sub_mul_div_unit_top.sv
// Top level of the signed add/sub/mul/div unit: front end, command queue, back end.
// Requests enter through push/full; results leave in order through empty/pop, one per request.
// Add, subtract and divide by zero go from the queue straight to the output state, with no iteration;
// multiply and divide run one operand bit per cycle sharing the acc, x and y shift registers,
// passing from the load through the iterations, sign fix-up and output to the result register.
// The two-entry command queue lets new requests be taken while the back end is iterating.
// Divide truncates toward zero; a zero divisor gives result 0 with divide_by_zero set;
// all results wrap modulo 2^32.
module signed_add_sub_mul_div_unit_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  ssmd_pkg::req_t request,
    output logic           empty,
    input  logic           pop,
    output ssmd_pkg::rsp_t response
);
    import ssmd_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_empty;
    logic queue_pop;

    ssmd_front u_front (
        .req (request),
        .cmd (front_cmd)
    );

    ssmd_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .q_full  (full),
        .rd_en   (queue_pop),
        .rd_data (queue_cmd),
        .q_empty (queue_empty)
    );

    ssmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_empty (queue_empty),
        .cmd_pop   (queue_pop),
        .rsp       (response),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
